### src/assert_macros.svh
// assertion macros shared by the scheduler modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// assert that an antecedent implies a consequent in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error(msg);
// assert that an antecedent implies a consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error(msg);
`endif

### src/mlfq_pkg.sv
// shared types and constants of the multilevel feedback queue scheduler
`default_nettype none
package mlfq_pkg;
    localparam int MAX_TASKS  = 16;
    localparam int MAX_LEVELS = 4;
    localparam int ID_W       = $clog2(MAX_TASKS);
    localparam int LVL_W      = 2;
    localparam int CNT_W      = $clog2(MAX_TASKS + 1);
    localparam int QD         = 2;

    localparam logic [2:0] REG_LEVELS = 3'd0;
    localparam logic [2:0] REG_Q0     = 3'd1;
    localparam logic [2:0] REG_Q1     = 3'd2;
    localparam logic [2:0] REG_Q2     = 3'd3;
    localparam logic [2:0] REG_Q3     = 3'd4;
    localparam logic [2:0] REG_FCFS   = 3'd5;

    localparam logic OP_ARRIVE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    typedef struct packed {
        logic        op;
        logic [3:0]  task_id;
        logic [15:0] burst;
    } in_item_t;

    typedef struct packed {
        logic [15:0] tick_time;
        logic        cpu_busy;
        logic [3:0]  running_id;
        logic        first_run;
        logic        finished;
        logic [1:0]  run_level;
    } out_item_t;

    // classified command from front to back
    typedef struct packed {
        logic        tick;
        logic [3:0]  id;
        logic [15:0] burst;
    } cmd_t;
endpackage
`default_nettype wire

### src/mlfq_ram.sv
// generic single write port ram with registered read
`default_nettype none
module mlfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### src/mlfq_front.sv
// input stage: classifies transactions and queues commands for the back end
`default_nettype none
`include "assert_macros.svh"
module mlfq_front
    import mlfq_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire in_item_t             in_data,
    output logic                      cmd_valid,
    input  wire logic                 cmd_take,
    output cmd_t                      cmd
);
    cmd_t               q_reg [QD];
    logic [1:0]         cnt_reg, cnt_next;
    logic               rd_reg, rd_next;
    logic               wr_reg, wr_next;
    logic               acc, push;

    assign in_stall  = (cnt_reg == 2'(QD));
    assign acc       = in_valid && !in_stall;
    // zero bursts never do anything; active ids are checked when executed
    assign push      = acc && (in_data.op == OP_TICK || in_data.burst != 16'd0);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg + 2'(push) - 2'(cmd_take);
        rd_next  = rd_reg ^ cmd_take;
        wr_next  = wr_reg ^ push;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= '{tick: in_data.op, id: in_data.task_id, burst: in_data.burst};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
        end
    end

    `ASSERT_IMPL(a_take_nonempty, clk, rst_n, cmd_take, cmd_valid, "take from empty queue")
    `ASSERT_IMPL(a_no_overflow, clk, rst_n, cnt_reg == 2'(QD), !push, "queue overflow")
endmodule
`default_nettype wire

### src/mlfq_back.sv
// execution stage: level fifos, task table and per tick dispatch
`default_nettype none
`include "assert_macros.svh"
module mlfq_back
    import mlfq_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [7:0]           cfg_data,
    input  wire logic                 cmd_valid,
    output logic                      cmd_take,
    input  wire cmd_t                 cmd,
    output logic                      valid,
    input  wire logic                 stall,
    output out_item_t                 result
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;

    logic [2:0]  lvls_reg;
    logic [7:0]  q_reg [4];
    logic        fcfs_reg;

    logic [1:0]  st_reg, st_next;
    logic [MAX_TASKS-1:0] act_reg;
    logic [MAX_TASKS-1:0] started_reg;
    logic [LVL_W-1:0]     tlvl_reg [MAX_TASKS];
    logic [15:0]          rem_reg [MAX_TASKS];
    logic [ID_W-1:0]      head_reg [MAX_LEVELS];
    logic [CNT_W-1:0]     cnt_reg [MAX_LEVELS];
    logic [ID_W-1:0]      run_reg;
    logic                 rv_reg;
    logic [7:0]           qu_reg;
    logic [15:0]          time_reg;
    logic                 ov_reg;
    out_item_t            res_reg;

    // fifo ram signals
    logic                 we;
    logic [5:0]           waddr, raddr;
    logic [ID_W-1:0]      wdata, rdata;
    // requeued task popped straight back from an empty level
    logic                 self_reg;

    mlfq_ram #(.WIDTH(ID_W), .DEPTH(MAX_LEVELS * MAX_TASKS)) u_fifo (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    // phase one decisions (combinational on current state)
    logic [1:0]  nlev;
    logic [1:0]  clvl;
    logic        higher, preempt, last, expire, requeue;
    logic [1:0]  push_lvl;
    logic [MAX_LEVELS-1:0] ne, ne_after;
    logic        any_pop;
    logic [1:0]  pop_lvl;
    logic [7:0]  qlim;

    always_comb
    begin
        nlev = (lvls_reg == 3'd0) ? 2'd0 : (lvls_reg > 3'd4) ? 2'd3 : 2'(lvls_reg - 3'd1);
        clvl = tlvl_reg[run_reg];
        higher = 1'b0;
        for (int k = 0; k < MAX_LEVELS; k++)
        begin
            ne[k] = (cnt_reg[k] != '0);
            if (k < int'(clvl) && ne[k])
            begin
                higher = 1'b1;
            end
        end
        qlim    = (q_reg[clvl] == 8'd0) ? 8'd1 : q_reg[clvl];
        last    = (clvl >= nlev);
        preempt = rv_reg && higher;
        expire  = rv_reg && !higher && !(last && fcfs_reg) && (qu_reg >= qlim);
        requeue = preempt || expire;
        push_lvl = (expire && !last) ? clvl + 2'd1 : clvl;
        ne_after = ne;
        if (requeue)
        begin
            ne_after[push_lvl] = 1'b1;
        end
        any_pop = 1'b0;
        pop_lvl = 2'd0;
        for (int k = MAX_LEVELS - 1; k >= 0; k--)
        begin
            if (ne_after[k])
            begin
                any_pop = 1'b1;
                pop_lvl = 2'(k);
            end
        end
        if (rv_reg && !requeue)
        begin
            any_pop = 1'b0;
        end
    end

    logic do_tick, do_arr, arr_ok;
    // a tick may start while the previous result leaves this cycle
    assign do_tick  = (st_reg == S_IDLE) && cmd_valid && cmd.tick && (!ov_reg || !stall);
    assign do_arr   = (st_reg == S_IDLE) && cmd_valid && !cmd.tick;
    assign arr_ok   = do_arr && cmd.burst != 16'd0 && !act_reg[cmd.id];
    assign cmd_take = do_arr || do_tick;

    always_comb
    begin
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        if (arr_ok)
        begin
            we    = 1'b1;
            waddr = {2'd0, ID_W'(head_reg[0] + ID_W'(cnt_reg[0]))};
            wdata = cmd.id;
        end
        else if (do_tick && requeue)
        begin
            we    = 1'b1;
            waddr = {push_lvl, ID_W'(head_reg[push_lvl] + ID_W'(cnt_reg[push_lvl]))};
            wdata = run_reg;
        end
        raddr = {pop_lvl, head_reg[pop_lvl]};
    end

    // phase two: run one unit for the task in rid
    logic [ID_W-1:0] rid;
    logic [15:0]     rem_dec;
    assign rid     = (st_reg == S_RUN && (rv_reg || self_reg)) ? run_reg : rdata;
    assign rem_dec = rem_reg[rid] - 16'(rem_reg[rid] != 16'd0);

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            S_IDLE:  if (do_tick) st_next = S_RUN;
            S_RUN:   st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    logic pop_reg;

    always_ff @(posedge clk)
    begin
        if (arr_ok)
        begin
            rem_reg[cmd.id]  <= cmd.burst;
            tlvl_reg[cmd.id] <= '0;
        end
        if (do_tick && expire)
        begin
            tlvl_reg[run_reg] <= push_lvl;
        end
        if (st_reg == S_RUN && (rv_reg || pop_reg))
        begin
            rem_reg[rid] <= rem_dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lvls_reg <= 3'd4;
            q_reg[0] <= 8'd8;
            q_reg[1] <= 8'd16;
            q_reg[2] <= 8'd32;
            q_reg[3] <= 8'd64;
            fcfs_reg <= 1'b1;
            st_reg   <= S_IDLE;
            act_reg  <= '0;
            started_reg <= '0;
            for (int k = 0; k < MAX_LEVELS; k++)
            begin
                head_reg[k] <= '0;
                cnt_reg[k]  <= '0;
            end
            run_reg  <= '0;
            rv_reg   <= 1'b0;
            qu_reg   <= '0;
            time_reg <= '0;
            ov_reg   <= 1'b0;
            res_reg  <= '0;
            pop_reg  <= 1'b0;
            self_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_LEVELS: lvls_reg <= cfg_data[2:0];
                    REG_Q0:     q_reg[0] <= cfg_data;
                    REG_Q1:     q_reg[1] <= cfg_data;
                    REG_Q2:     q_reg[2] <= cfg_data;
                    REG_Q3:     q_reg[3] <= cfg_data;
                    REG_FCFS:   fcfs_reg <= cfg_data[0];
                    default:    ;
                endcase
            end
            if (ov_reg && !stall)
            begin
                ov_reg <= 1'b0;
            end
            if (arr_ok)
            begin
                act_reg[cmd.id]     <= 1'b1;
                started_reg[cmd.id] <= 1'b0;
                cnt_reg[0]          <= cnt_reg[0] + 1'b1;
            end
            if (do_tick)
            begin
                pop_reg  <= any_pop;
                self_reg <= requeue && any_pop && pop_lvl == push_lvl &&
                            cnt_reg[push_lvl] == '0;
                if (requeue)
                begin
                    rv_reg <= 1'b0;
                end
                for (int k = 0; k < MAX_LEVELS; k++)
                begin
                    cnt_reg[k] <= cnt_reg[k]
                        + CNT_W'(requeue && push_lvl == 2'(k))
                        - CNT_W'(any_pop && pop_lvl == 2'(k));
                end
                if (any_pop)
                begin
                    head_reg[pop_lvl] <= head_reg[pop_lvl] + 1'b1;
                end
            end
            if (st_reg == S_RUN)
            begin
                ov_reg <= 1'b1;
                res_reg.tick_time <= time_reg;
                time_reg <= time_reg + 16'd1;
                if (rv_reg || pop_reg)
                begin
                    run_reg <= rid;
                    res_reg.cpu_busy   <= 1'b1;
                    res_reg.running_id <= rid;
                    res_reg.first_run  <= !started_reg[rid];
                    res_reg.run_level  <= tlvl_reg[rid];
                    res_reg.finished   <= (rem_dec == 16'd0);
                    started_reg[rid]   <= 1'b1;
                    qu_reg <= (pop_reg ? 8'd0 : qu_reg) +
                              8'((pop_reg ? 8'd0 : qu_reg) != 8'd255);
                    rv_reg <= (rem_dec != 16'd0);
                    if (rem_dec == 16'd0)
                    begin
                        act_reg[rid] <= 1'b0;
                    end
                end
                else
                begin
                    res_reg.cpu_busy   <= 1'b0;
                    res_reg.running_id <= '0;
                    res_reg.first_run  <= 1'b0;
                    res_reg.run_level  <= '0;
                    res_reg.finished   <= 1'b0;
                end
            end
        end
    end

    // rid is read in S_RUN; during pop path rv_reg was cleared or was zero
    assign valid  = ov_reg;
    assign result = res_reg;

    `ASSERT_NEXT(a_tick_two, clk, rst_n, do_tick, st_reg == S_RUN, "tick not in run phase")
    `ASSERT_IMPL(a_busy_active, clk, rst_n, rv_reg && st_reg == S_IDLE, act_reg[run_reg],
        "running task not active")
endmodule
`default_nettype wire

### src/mlfq_cpu_scheduler.sv
// top level of the multilevel feedback queue scheduler
// arrive: taken from the command queue while idle, no result
// tick: in the back end, decide and fifo read, then run and write back
// result shows in the cycle after the run phase; ticks do not overlap
// a two entry command queue decouples input from execution
// reset: async active low, clears queues, active table and registers to defaults
`default_nettype none
module mlfq_cpu_scheduler
    import mlfq_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [2:0] cfg_index,
    input  wire logic [7:0] cfg_data,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire in_item_t   in_data,
    output logic            out_valid,
    input  wire logic       out_stall,
    output out_item_t       out_data
);
    logic                 cmd_valid, cmd_take;
    cmd_t                 cmd;

    mlfq_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_data(in_data), .cmd_valid(cmd_valid),
        .cmd_take(cmd_take), .cmd(cmd)
    );

    mlfq_back u_back (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd),
        .valid(out_valid), .stall(out_stall), .result(out_data)
    );
endmodule
`default_nettype wire
